/* hdl/tma_pkg.sv */
// shared types, constants and the saturating-add helper function of the triangle moment accumulator
package tma_pkg;

  localparam int CoordW  = 16;
  localparam int DiffW   = CoordW + 1;
  localparam int ProdW   = 2 * DiffW;
  localparam int CrossW  = ProdW + 1;
  localparam int MagW    = CrossW - 1;
  localparam int SqW     = 2 * MagW;
  localparam int SumW    = SqW + 2;
  localparam int RadW    = 72;
  localparam int RootW   = RadW / 2;
  localparam int RemW    = RootW + 3;
  localparam int WeightW = 32;
  localparam int AccW    = 64;
  localparam int CountW  = 32;
  localparam int SelW    = 4;
  localparam int RootBitsPerCycle = 2;
  localparam int RootCycles       = RootW / RootBitsPerCycle;
  localparam int RootCntW         = $clog2(RootCycles + 1);

  localparam logic [SelW-1:0] SelWeight = 4'd0;
  localparam logic [SelW-1:0] SelFirst  = 4'd1;
  localparam logic [SelW-1:0] SelSquare = 4'd4;
  localparam logic [SelW-1:0] SelCross  = 4'd7;
  localparam logic [SelW-1:0] SelNormal = 4'd10;
  localparam logic [SelW-1:0] SelCount  = 4'd13;

  localparam logic [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_NORMAL = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DEGEN = 2'd1,
    STAT_READ  = 2'd2,
    STAT_SAT   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_PROD,
    S_CROSS,
    S_SQ,
    S_SUM,
    S_CHK,
    S_ROOT,
    S_LANE1,
    S_LANE2,
    S_MERGE,
    S_OUT
  } state_e;

  typedef logic [2:0][CoordW-1:0] vec_t;

  typedef struct packed {
    logic [WeightW-1:0]      w;
    logic [2:0][AccW-1:0]    fm;
    logic [2:0][AccW-1:0]    sq;
    logic [2:0][AccW-1:0]    cr;
    logic [2:0][AccW-1:0]    nm;
  } terms_t;

  typedef struct packed {
    logic add_en;
    logic count_en;
    logic norm_we;
  } acc_ctrl_t;

  // saturating signed add, returns {clip, sum}
  function automatic logic [AccW:0] sat_add(input logic [AccW-1:0] a,
                                            input logic [AccW-1:0] t);
    logic [AccW-1:0] s;
    s = a + t;
    if (a[AccW-1] == t[AccW-1] && s[AccW-1] != a[AccW-1]) begin
      return {1'b1, a[AccW-1] ? AccMin : AccMax};
    end
    return {1'b0, s};
  endfunction

endpackage

/* hdl/tma_root.sv */
// digit-by-digit square root with the divide-by-six of the root folded in
module tma_root (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tma_pkg::RadW-1:0]    rad_i,
  output logic                        done_o,
  output logic [tma_pkg::WeightW-1:0] weight_o
);
  import tma_pkg::*;

  logic [RadW-1:0]     rad_q, rad_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [RootW-1:0]    root_q, root_d;
  logic [WeightW-1:0]  quo_q, quo_d;
  logic [1:0]          r3_q, r3_d;
  logic [RootCntW-1:0] cnt_q;
  logic                done_q;

  always_comb begin
    logic [RemW-1:0] trial;
    logic            b;
    logic [2:0]      v;
    logic            qb;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    quo_d  = quo_q;
    r3_d   = r3_q;
    for (int j = 0; j < RootBitsPerCycle; j++) begin
      rem_d = {rem_d[RemW-3:0], rad_d[RadW-1 -: 2]};
      rad_d = {rad_d[RadW-3:0], 2'b00};
      trial = {1'b0, root_d, 2'b01};
      b     = (rem_d >= trial);
      if (b) begin
        rem_d = rem_d - trial;
      end
      root_d = {root_d[RootW-2:0], b};
      // the final root bit is dropped: root / 6 == (root >> 1) / 3
      if (!(cnt_q == RootCntW'(1) && j == RootBitsPerCycle - 1)) begin
        v     = {r3_d, 1'b0} + {2'b00, b};
        qb    = (v >= 3'd3);
        r3_d  = qb ? 2'(v - 3'd3) : v[1:0];
        quo_d = {quo_d[WeightW-2:0], qb};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= RootCntW'(RootCycles);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == RootCntW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
      quo_q  <= '0;
      r3_q   <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      quo_q  <= quo_d;
      r3_q   <= r3_d;
    end
  end

  assign done_o   = done_q;
  assign weight_o = quo_q;

endmodule

/* hdl/tma_lane.sv */
// per-vertex lane: weighted moment terms in two multiply stages
module tma_lane (
  input  logic                        clk_i,
  input  logic                        en1_i,
  input  logic                        en2_i,
  input  logic [tma_pkg::WeightW-1:0] w_i,
  input  tma_pkg::vec_t               vert_i,
  input  tma_pkg::vec_t               norm_i,
  output tma_pkg::terms_t             terms_o
);
  import tma_pkg::*;

  localparam int WvW = WeightW + CoordW + 1;

  logic signed [WvW-1:0]  wv_q [3];
  logic signed [WvW-1:0]  wn_q [3];
  logic [WeightW-1:0]     w_q;
  terms_t                 terms_q;

  always_ff @(posedge clk_i) begin
    logic signed [WvW-1:0]  wa;
    logic signed [AccW-1:0] pa, pv, pr;
    wa = $signed({{(WvW-WeightW){1'b0}}, w_i});
    if (en1_i) begin
      w_q <= w_i;
      for (int i = 0; i < 3; i++) begin
        wv_q[i] <= wa * WvW'($signed(vert_i[i]));
        wn_q[i] <= wa * WvW'($signed(norm_i[i]));
      end
    end
    if (en2_i) begin
      terms_q.w <= w_q;
      for (int i = 0; i < 3; i++) begin
        pa = AccW'(wv_q[i]);
        pv = AccW'($signed(vert_i[i]));
        pr = AccW'($signed(vert_i[(i + 1) % 3]));
        terms_q.fm[i] <= pa;
        terms_q.nm[i] <= AccW'(wn_q[i]);
        terms_q.sq[i] <= pa * pv;
        terms_q.cr[i] <= pa * pr;
      end
    end
  end

  assign terms_o = terms_q;

endmodule

/* hdl/tma_accum.sv */
// saturating accumulators, held normal, triangle count and read select
module tma_accum (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tma_pkg::acc_ctrl_t       ctrl_i,
  input  tma_pkg::terms_t          terms_i,
  input  tma_pkg::vec_t            norm_i,
  input  logic [tma_pkg::SelW-1:0] sel_i,
  output tma_pkg::vec_t            norm_o,
  output logic                     clip_o,
  output logic [tma_pkg::AccW-1:0] value_o
);
  import tma_pkg::*;

  logic [AccW-1:0]      tw_q, tw_d;
  logic [2:0][AccW-1:0] fm_q, fm_d, sq_q, sq_d, cr_q, cr_d, nm_q, nm_d;
  logic [CountW-1:0]    cnt_q, cnt_d;
  vec_t                 norm_q;

  always_comb begin
    logic [AccW:0] r;
    logic          clip;
    clip  = 1'b0;
    r     = sat_add(tw_q, {{(AccW-WeightW){1'b0}}, terms_i.w});
    tw_d  = r[AccW-1:0];
    clip |= r[AccW];
    for (int i = 0; i < 3; i++) begin
      r = sat_add(fm_q[i], terms_i.fm[i]); fm_d[i] = r[AccW-1:0]; clip |= r[AccW];
      r = sat_add(sq_q[i], terms_i.sq[i]); sq_d[i] = r[AccW-1:0]; clip |= r[AccW];
      r = sat_add(cr_q[i], terms_i.cr[i]); cr_d[i] = r[AccW-1:0]; clip |= r[AccW];
      r = sat_add(nm_q[i], terms_i.nm[i]); nm_d[i] = r[AccW-1:0]; clip |= r[AccW];
    end
    cnt_d = cnt_q;
    if (ctrl_i.count_en) begin
      if (cnt_q == '1) begin
        clip = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    clip_o = ctrl_i.add_en && clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q   <= '0;
      fm_q   <= '0;
      sq_q   <= '0;
      cr_q   <= '0;
      nm_q   <= '0;
      cnt_q  <= '0;
      norm_q <= '0;
    end else begin
      if (ctrl_i.add_en) begin
        tw_q  <= tw_d;
        fm_q  <= fm_d;
        sq_q  <= sq_d;
        cr_q  <= cr_d;
        nm_q  <= nm_d;
        cnt_q <= cnt_d;
      end
      if (ctrl_i.norm_we) begin
        norm_q <= norm_i;
      end
    end
  end

  always_comb begin
    value_o = '0;
    unique case (sel_i) inside
      SelWeight:                    value_o = tw_q;
      [SelFirst:SelFirst + 4'd2]:   value_o = fm_q[2'(sel_i - SelFirst)];
      [SelSquare:SelSquare + 4'd2]: value_o = sq_q[2'(sel_i - SelSquare)];
      [SelCross:SelCross + 4'd2]:   value_o = cr_q[2'(sel_i - SelCross)];
      [SelNormal:SelNormal + 4'd2]: value_o = nm_q[2'(sel_i - SelNormal)];
      SelCount:                     value_o = {{(AccW-CountW){1'b0}}, cnt_q};
      default:                      value_o = '0;
    endcase
  end

  assign norm_o = norm_q;

endmodule

/* hdl/triangle_moment_accumulator_core.sv */
// top level: command sequencer, cross product front end, three vertex lanes and merge
// insert: front end, square root, lanes, merge, then output; a zero-area triangle skips from the check to output
//   front end: difference, product, cross, square, sum and check; square root (two root bits a cycle, then done);
//   lanes: weight multiply, then moment multiply; merge: the three lanes' terms added in turn; then the output state
// set normal, read and unused commands: straight from idle to the output state
// one transaction at a time; reset clears all accumulators, the count and the held normal
module triangle_moment_accumulator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 cmd_i,
  input  logic signed [15:0]         a_x_i,
  input  logic signed [15:0]         a_y_i,
  input  logic signed [15:0]         a_z_i,
  input  logic signed [15:0]         b_x_i,
  input  logic signed [15:0]         b_y_i,
  input  logic signed [15:0]         b_z_i,
  input  logic signed [15:0]         c_x_i,
  input  logic signed [15:0]         c_y_i,
  input  logic signed [15:0]         c_z_i,
  input  logic [tma_pkg::SelW-1:0]   sel_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic signed [63:0]         value_o
);
  import tma_pkg::*;

  state_e state_q, state_d;

  cmd_e               cmd_q;
  vec_t               vert_q [3];
  logic [SelW-1:0]    sel_q;
  logic signed [DiffW-1:0]  d_q [3], e_q [3];
  logic signed [ProdW-1:0]  p_q [6];
  logic signed [CrossW-1:0] c_q [3];
  logic [SqW-1:0]     sq_q [3];
  logic [SumW-1:0]    sum_q;
  logic [1:0]         mk_q;
  logic               clip_q, degen_q;
  logic               out_valid_q;
  status_e            status_q;
  logic [AccW-1:0]    value_q;

  logic               accept, out_free, root_start, root_done, lane_en1, lane_en2, clip;
  logic [WeightW-1:0] weight;
  acc_ctrl_t          actrl;
  terms_t             terms [3];
  terms_t             terms_sel;
  vec_t               norm;
  logic [AccW-1:0]    rd_value;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = (cmd_e'(cmd_i) == CMD_INSERT) ? S_DIFF : S_OUT;
      S_DIFF:  state_d = S_PROD;
      S_PROD:  state_d = S_CROSS;
      S_CROSS: state_d = S_SQ;
      S_SQ:    state_d = S_SUM;
      S_SUM:   state_d = S_CHK;
      S_CHK:   state_d = (sum_q == '0) ? S_OUT : S_ROOT;
      S_ROOT:  if (root_done) state_d = S_LANE1;
      S_LANE1: state_d = S_LANE2;
      S_LANE2: state_d = S_MERGE;
      S_MERGE: if (mk_q == 2'd2) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == S_IDLE);
    root_start     = (state_q == S_CHK) && (sum_q != '0);
    lane_en1       = (state_q == S_LANE1);
    lane_en2       = (state_q == S_LANE2);
    actrl.add_en   = (state_q == S_MERGE);
    actrl.count_en = (state_q == S_MERGE) && (mk_q == 2'd2);
    actrl.norm_we  = (state_q == S_OUT) && out_free && (cmd_q == CMD_NORMAL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mk_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_MERGE) begin
        mk_q <= (mk_q == 2'd2) ? 2'd0 : mk_q + 2'd1;
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [MagW-1:0] mag;
    if (accept) begin
      cmd_q     <= cmd_e'(cmd_i);
      sel_q     <= sel_i;
      vert_q[0] <= {a_z_i, a_y_i, a_x_i};
      vert_q[1] <= {b_z_i, b_y_i, b_x_i};
      vert_q[2] <= {c_z_i, c_y_i, c_x_i};
      clip_q    <= 1'b0;
      degen_q   <= 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      if (state_q == S_DIFF) begin
        d_q[i] <= DiffW'($signed(vert_q[1][i])) - DiffW'($signed(vert_q[0][i]));
        e_q[i] <= DiffW'($signed(vert_q[2][i])) - DiffW'($signed(vert_q[0][i]));
      end
      if (state_q == S_CROSS) begin
        c_q[i] <= CrossW'(p_q[2*i]) - CrossW'(p_q[2*i+1]);
      end
      if (state_q == S_SQ) begin
        mag = c_q[i][CrossW-1] ? MagW'(-c_q[i]) : MagW'(c_q[i]);
        sq_q[i] <= SqW'(mag) * SqW'(mag);
      end
    end
    if (state_q == S_PROD) begin
      p_q[0] <= ProdW'(d_q[1]) * ProdW'(e_q[2]);
      p_q[1] <= ProdW'(d_q[2]) * ProdW'(e_q[1]);
      p_q[2] <= ProdW'(d_q[2]) * ProdW'(e_q[0]);
      p_q[3] <= ProdW'(d_q[0]) * ProdW'(e_q[2]);
      p_q[4] <= ProdW'(d_q[0]) * ProdW'(e_q[1]);
      p_q[5] <= ProdW'(d_q[1]) * ProdW'(e_q[0]);
    end
    if (state_q == S_SUM) begin
      sum_q <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
    end
    if (state_q == S_CHK && sum_q == '0) begin
      degen_q <= 1'b1;
    end
    if (clip) begin
      clip_q <= 1'b1;
    end
    if (state_q == S_OUT && out_free) begin
      value_q <= '0;
      unique case (cmd_q)
        CMD_INSERT: status_q <= degen_q ? STAT_DEGEN : (clip_q ? STAT_SAT : STAT_OK);
        CMD_READ: begin
          status_q <= STAT_READ;
          value_q  <= rd_value;
        end
        default:    status_q <= STAT_OK;
      endcase
    end
  end

  tma_root u_root (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (root_start),
    .rad_i    (RadW'(sum_q)),
    .done_o   (root_done),
    .weight_o (weight)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tma_lane u_lane (
      .clk_i   (clk_i),
      .en1_i   (lane_en1),
      .en2_i   (lane_en2),
      .w_i     (weight),
      .vert_i  (vert_q[k]),
      .norm_i  (norm),
      .terms_o (terms[k])
    );
  end

  always_comb begin
    case (mk_q)
      2'd0:    terms_sel = terms[0];
      2'd1:    terms_sel = terms[1];
      default: terms_sel = terms[2];
    endcase
  end

  tma_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (actrl),
    .terms_i (terms_sel),
    .norm_i  (vert_q[0]),
    .sel_i   (sel_q),
    .norm_o  (norm),
    .clip_o  (clip),
    .value_o (rd_value)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_o     = value_q;

endmodule

/* hdl/tma_checker.sv */
// port-level checker for the triangle moment accumulator and its bind
module tma_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  cmd_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [63:0] value_o
);
  import tma_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(value_o))
    else $error("result changed while stalled");

  // only reads carry a value
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_READ |-> value_o == '0)
    else $error("nonzero value on a non-read result");

  // one transaction in flight
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // with the output empty, a short command's result comes up once it has passed the output state
  a_short_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o && cmd_i != CMD_INSERT |-> ##2 out_valid_o)
    else $error("short command result missing");

endmodule

bind triangle_moment_accumulator_core tma_checker u_tma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .value_o     (value_o)
);

/* test/triangle_moment_accumulator_core_checker.sv */
// checker: predicts every result of the triangle moment accumulator and compares it
`timescale 1ns / 1ps
module triangle_moment_accumulator_core_checker
  import tma_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         cmd_i,
  input  logic signed [15:0] a_x_i,
  input  logic signed [15:0] a_y_i,
  input  logic signed [15:0] a_z_i,
  input  logic signed [15:0] b_x_i,
  input  logic signed [15:0] b_y_i,
  input  logic signed [15:0] b_z_i,
  input  logic signed [15:0] c_x_i,
  input  logic signed [15:0] c_y_i,
  input  logic signed [15:0] c_z_i,
  input  logic [SelW-1:0]    sel_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         status_i,
  input  logic signed [63:0] value_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] value;
  } moment_result_t;

  logic signed [63:0] weight_sum;
  logic signed [63:0] first_sum  [3];
  logic signed [63:0] square_sum [3];
  logic signed [63:0] cross_sum  [3];
  logic signed [63:0] normal_sum [3];
  logic [31:0]        tri_count;
  logic signed [15:0] normal_hold [3];
  moment_result_t     expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic [127:0] isqrt(input logic [127:0] x);
    logic [127:0] r;
    logic [127:0] t;
    r = 0;
    for (int b = 40; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic void acc_add(ref logic signed [63:0] acc,
                                  input logic signed [127:0] t, ref bit clip);
    logic signed [127:0] s;
    s = 128'(acc) + t;
    if (s > 128'sh7fffffffffffffff) begin
      acc = 64'sh7fffffffffffffff; clip = 1;
    end else if (s < -128'sh8000000000000000) begin
      acc = 64'sh8000000000000000; clip = 1;
    end else acc = s[63:0];
  endfunction

  function automatic moment_result_t predict_moments(input logic [1:0] cmd,
      input logic signed [15:0] v [3][3], input logic [3:0] sel);
    moment_result_t r;
    logic signed [127:0] d [3];
    logic signed [127:0] e [3];
    logic signed [127:0] c [3];
    logic signed [127:0] w;
    logic signed [127:0] wv;
    logic [127:0] mag2;
    bit clip;
    r = '0;
    clip = 0;
    case (cmd)
      CMD_NORMAL: for (int i = 0; i < 3; i++) normal_hold[i] = v[0][i];
      CMD_INSERT: begin
        for (int i = 0; i < 3; i++) begin
          d[i] = v[1][i] - v[0][i];
          e[i] = v[2][i] - v[0][i];
        end
        c[0] = d[1] * e[2] - d[2] * e[1];
        c[1] = d[2] * e[0] - d[0] * e[2];
        c[2] = d[0] * e[1] - d[1] * e[0];
        mag2 = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
        if (mag2 == 0) r.status = STAT_DEGEN;
        else begin
          w = isqrt(mag2) / 6;
          for (int k = 0; k < 3; k++) begin
            acc_add(weight_sum, w, clip);
            for (int i = 0; i < 3; i++) begin
              wv = w * v[k][i];
              acc_add(first_sum[i], wv, clip);
              acc_add(square_sum[i], wv * v[k][i], clip);
              acc_add(cross_sum[i], wv * v[k][(i + 1) % 3], clip);
              acc_add(normal_sum[i], w * normal_hold[i], clip);
            end
          end
          if (tri_count == '1) clip = 1;
          else tri_count++;
          r.status = clip ? STAT_SAT : STAT_OK;
        end
      end
      CMD_READ: begin
        r.status = STAT_READ;
        if (sel == SelWeight) r.value = weight_sum;
        else if (sel < SelSquare) r.value = first_sum[sel - SelFirst];
        else if (sel < SelCross) r.value = square_sum[sel - SelSquare];
        else if (sel < SelNormal) r.value = cross_sum[sel - SelCross];
        else if (sel < SelCount) r.value = normal_sum[sel - SelNormal];
        else if (sel == SelCount) r.value = {32'd0, tri_count};
      end
      default: ;
    endcase
    return r;
  endfunction

  logic signed [15:0] verts [3][3];
  moment_result_t exp_r;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_sum <= 0;
      tri_count <= 0;
      fail_count_o <= 0;
      for (int i = 0; i < 3; i++) begin
        first_sum[i] <= 0; square_sum[i] <= 0; cross_sum[i] <= 0;
        normal_sum[i] <= 0; normal_hold[i] <= 0;
      end
      expected_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        verts[0] = '{a_x_i, a_y_i, a_z_i};
        verts[1] = '{b_x_i, b_y_i, b_z_i};
        verts[2] = '{c_x_i, c_y_i, c_z_i};
        expected_q.push_back(predict_moments(cmd_i, verts, sel_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result status %0d value %0d", $time, status_i, value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.status !== status_i || exp_r.value !== value_i) begin
            $display("%0t: mismatch expected status %0d value %0d, actual status %0d value %0d",
                     $time, exp_r.status, exp_r.value, status_i, value_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

/* test/triangle_moment_accumulator_core_tb.sv */
// testbench top: stimulus, handshake idling and verdict for the triangle moment accumulator
`timescale 1ns / 1ps
module triangle_moment_accumulator_core_tb;
  import tma_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [1:0] cmd_i = CMD_NONE;
  logic signed [15:0] a_x_i = 0, a_y_i = 0, a_z_i = 0;
  logic signed [15:0] b_x_i = 0, b_y_i = 0, b_z_i = 0;
  logic signed [15:0] c_x_i = 0, c_y_i = 0, c_z_i = 0;
  logic [SelW-1:0] sel_i = 0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic [1:0] status_o;
  logic signed [63:0] value_o;
  int fail_count;
  int pending;
  int send_idle = 13;
  int recv_idle = 86;
  bit hold_off = 0;

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  triangle_moment_accumulator_core DUT (.*);

  triangle_moment_accumulator_core_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i,
    .a_x_i, .a_y_i, .a_z_i, .b_x_i, .b_y_i, .b_z_i, .c_x_i, .c_y_i, .c_z_i,
    .sel_i, .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .value_i(value_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  task automatic send_cmd(input logic [1:0] cmd, input logic signed [15:0] v [9],
                          input logic [3:0] sel);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    cmd_i <= cmd;
    {a_x_i, a_y_i, a_z_i} <= {v[0], v[1], v[2]};
    {b_x_i, b_y_i, b_z_i} <= {v[3], v[4], v[5]};
    {c_x_i, c_y_i, c_z_i} <= {v[6], v[7], v[8]};
    sel_i <= sel;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return $signed(16'($urandom_range(15))) - 8;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic rand_item();
    logic signed [15:0] v [9];
    int pick;
    for (int i = 0; i < 9; i++) v[i] = rand_coord();
    pick = $urandom_range(99);
    if (pick < 10) begin
      v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
    end else if (pick < 15) begin
      v[6] = v[0] + (v[3] - v[0]); v[7] = v[1] + (v[4] - v[1]); v[8] = v[2] + (v[5] - v[2]);
    end
    pick = $urandom_range(99);
    if (pick < 45) send_cmd(CMD_INSERT, v, 4'($urandom));
    else if (pick < 80) send_cmd(CMD_READ, v, 4'($urandom));
    else if (pick < 95) send_cmd(CMD_NORMAL, v, 4'($urandom));
    else send_cmd(CMD_NONE, v, 4'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic signed [15:0] v [9];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed part
    v = '{default: 16'sh7fff};
    send_cmd(CMD_NORMAL, v, 0);
    v = '{-16'sh8000, -16'sh8000, -16'sh8000, 16'sh7fff, -16'sh8000, -16'sh8000,
          -16'sh8000, 16'sh7fff, 16'sh7fff};
    send_cmd(CMD_INSERT, v, 0);
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_cmd(CMD_INSERT, v, 0);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_cmd(CMD_INSERT, v, 15);
    v = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
    send_cmd(CMD_INSERT, v, 0);
    v = '{-16'sh8000, -16'sh8000, -16'sh8000, 0, 0, 0, 0, 0, 0};
    send_cmd(CMD_NORMAL, v, 0);
    send_cmd(CMD_NONE, v, 4'hf);
    for (int s = 0; s < 16; s++) send_cmd(CMD_READ, v, 4'(s));
    v = '{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000,
          16'sh7fff, 16'sh7fff, -16'sh8000};
    for (int k = 0; k < 40; k++) send_cmd(CMD_INSERT, v, 0);
    for (int s = 0; s < 14; s++) send_cmd(CMD_READ, v, 4'(s));
    wait_drained();
    // random part in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 86; recv_idle = 13; end
      if (ph == 2) begin send_idle = 0; recv_idle = 0; end
      for (int n = 0; n < 150; n++) rand_item();
      wait_drained();
    end
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    wait (rst_ni);
    repeat (200) @(posedge clk_i);
    hold_off = 1;
    repeat (300) @(posedge clk_i);
    hold_off = 0;
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
